FILE: hdl/lcdr_pkg.sv
package lcdr_pkg;

    localparam int CHARS_PER_LINE = 20;
    localparam int LINES          = 4;
    localparam int CELLS          = CHARS_PER_LINE * LINES;
    localparam int CELL_W         = $clog2(CELLS);
    localparam int COL_W          = $clog2(CHARS_PER_LINE);
    localparam int INIT_BYTES     = 8;
    localparam int CNT_W          = (COL_W > 3) ? COL_W : 3;

    localparam logic [7:0]  SPACE_CHAR   = 8'h20;
    localparam logic [7:0]  CMD_CLEAR    = 8'h01;
    localparam logic [11:0] POWER_UP_10US = 12'd4000;
    localparam logic [8:0]  WAIT_SHORT   = 9'd5;
    localparam logic [8:0]  WAIT_LONG    = 9'd200;

    typedef enum logic [1:0] {
        KIND_INIT    = 2'd0,
        KIND_STORE   = 2'd1,
        KIND_REFRESH = 2'd2,
        KIND_ERASE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SRC_INIT  = 2'd0,
        SRC_ADDR  = 2'd1,
        SRC_CHAR  = 2'd2,
        SRC_ERASE = 2'd3
    } src_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_HI,
        ST_INIT_LO,
        ST_ADDR_HI,
        ST_ADDR_LO,
        ST_FETCH,
        ST_CHAR_HI,
        ST_CHAR_LO,
        ST_ERASE_HI,
        ST_ERASE_LO
    } state_t;

    typedef struct packed {
        logic store_cell;
        logic clear_store;
        logic set_init;
        logic load_line;
        logic cnt_clr;
        logic cnt_inc;
        logic fetch;
        logic emit;
        logic low;
        logic last;
        src_t src;
    } lcdr_cmd_t;

    typedef struct packed {
        logic  out_free;
        logic  initialized;
        logic  init_end;
        logic  col_end;
        logic  line_ok;
        kind_t kind;
    } lcdr_status_t;

    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0, 3'd1, 3'd2: b = 8'h30;
            3'd3:             b = 8'h20;
            3'd4:             b = 8'h08;
            3'd5:             b = 8'h0C;
            3'd6:             b = 8'h06;
            default:          b = 8'h02;
        endcase
        return b;
    endfunction

    function automatic logic [8:0] init_wait(input logic [2:0] idx);
        logic [8:0] w;
        unique case (idx)
            3'd0:       w = 9'd500;
            3'd1, 3'd2: w = 9'd20;
            default:    w = WAIT_SHORT;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] line_cmd(input logic [1:0] ln);
        logic [7:0] b;
        unique case (ln)
            2'd0:    b = 8'h02;
            2'd1:    b = 8'hC0;
            2'd2:    b = 8'h94;
            default: b = 8'hD4;
        endcase
        return b;
    endfunction

endpackage

FILE: hdl/lcdr_ctrl.sv
module lcdr_ctrl
    import lcdr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  lcdr_status_t status,
    output lcdr_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (status.kind)
                        KIND_INIT:
                        begin
                            if (!status.initialized)
                            begin
                                state_next = ST_INIT_HI;
                            end
                        end
                        KIND_STORE:
                        begin
                            state_next = ST_IDLE;
                        end
                        KIND_REFRESH:
                        begin
                            if (status.line_ok)
                            begin
                                state_next = ST_ADDR_HI;
                            end
                        end
                        KIND_ERASE:
                        begin
                            state_next = ST_ERASE_HI;
                        end
                    endcase
                end
            end
            ST_INIT_HI:
            begin
                if (status.out_free)
                begin
                    state_next = ST_INIT_LO;
                end
            end
            ST_INIT_LO:
            begin
                if (status.out_free)
                begin
                    state_next = status.init_end ? ST_IDLE : ST_INIT_HI;
                end
            end
            ST_ADDR_HI:
            begin
                if (status.out_free)
                begin
                    state_next = ST_ADDR_LO;
                end
            end
            ST_ADDR_LO:
            begin
                if (status.out_free)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_CHAR_HI;
            end
            ST_CHAR_HI:
            begin
                if (status.out_free)
                begin
                    state_next = ST_CHAR_LO;
                end
            end
            ST_CHAR_LO:
            begin
                if (status.out_free)
                begin
                    state_next = status.col_end ? ST_IDLE : ST_FETCH;
                end
            end
            ST_ERASE_HI:
            begin
                if (status.out_free)
                begin
                    state_next = ST_ERASE_LO;
                end
            end
            ST_ERASE_LO:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.src  = SRC_INIT;
        in_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (status.kind)
                        KIND_INIT:
                        begin
                            cmd.clear_store = !status.initialized;
                            cmd.set_init    = !status.initialized;
                            cmd.cnt_clr     = 1'b1;
                        end
                        KIND_STORE:
                        begin
                            cmd.store_cell = 1'b1;
                        end
                        KIND_REFRESH:
                        begin
                            cmd.load_line = status.line_ok;
                            cmd.cnt_clr   = 1'b1;
                        end
                        KIND_ERASE:
                        begin
                            cmd.clear_store = 1'b1;
                        end
                    endcase
                end
            end
            ST_INIT_HI:
            begin
                cmd.src  = SRC_INIT;
                cmd.emit = status.out_free;
            end
            ST_INIT_LO:
            begin
                cmd.src     = SRC_INIT;
                cmd.low     = 1'b1;
                cmd.emit    = status.out_free;
                cmd.last    = status.init_end;
                cmd.cnt_inc = status.out_free && !status.init_end;
            end
            ST_ADDR_HI:
            begin
                cmd.src  = SRC_ADDR;
                cmd.emit = status.out_free;
            end
            ST_ADDR_LO:
            begin
                cmd.src  = SRC_ADDR;
                cmd.low  = 1'b1;
                cmd.emit = status.out_free;
            end
            ST_FETCH:
            begin
                cmd.src   = SRC_CHAR;
                cmd.fetch = 1'b1;
            end
            ST_CHAR_HI:
            begin
                cmd.src  = SRC_CHAR;
                cmd.emit = status.out_free;
            end
            ST_CHAR_LO:
            begin
                cmd.src     = SRC_CHAR;
                cmd.low     = 1'b1;
                cmd.emit    = status.out_free;
                cmd.last    = status.col_end;
                cmd.cnt_inc = status.out_free && !status.col_end;
            end
            ST_ERASE_HI:
            begin
                cmd.src  = SRC_ERASE;
                cmd.emit = status.out_free;
            end
            ST_ERASE_LO:
            begin
                cmd.src  = SRC_ERASE;
                cmd.low  = 1'b1;
                cmd.emit = status.out_free;
                cmd.last = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // never load the output register over a beat that is still held
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("strobe emitted while output register busy");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("controller busy after final strobe");

    a_fetch_char: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fetch |=> (state_reg == ST_CHAR_HI))
        else $error("cell read not followed by character strobe");
`endif

endmodule

FILE: hdl/lcdr_dp.sv
module lcdr_dp
    import lcdr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [1:0]   kind,
    input  logic [6:0]   position,
    input  logic [7:0]   character,
    input  logic [1:0]   line,
    input  lcdr_cmd_t    cmd,
    output lcdr_status_t status,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         reg_select,
    output logic [3:0]   nibble,
    output logic [11:0]  lead_wait_10us,
    output logic [8:0]   wait_after_10us,
    output logic         last
);

    logic [7:0]        mem [CELLS];
    logic [CELLS-1:0]  valid_reg;
    logic              init_reg;
    logic              blank_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CELL_W-1:0] cell_addr_reg;
    logic [1:0]        line_reg;
    logic [7:0]        rd_data_reg;
    logic              rd_valid_reg;

    logic              out_valid_reg;
    logic              rs_reg;
    logic [3:0]        nibble_reg;
    logic [11:0]       lead_reg;
    logic [8:0]        after_reg;
    logic              last_reg;

    logic [CELL_W-1:0] pos_addr;
    logic              pos_ok;
    logic              char_blank;
    logic [7:0]        cur_byte;
    logic              cur_rs;
    logic [11:0]       cur_lead;
    logic [8:0]        cur_after;
    logic              blank_hit;

    assign pos_addr = CELL_W'(position);
    assign pos_ok   = (int'(position) < CELLS);

    // a zero cell turns itself and the rest of its line into spaces
    assign char_blank = blank_reg || (rd_valid_reg && (rd_data_reg == 8'h00));
    assign blank_hit  = cmd.emit && !cmd.low && (cmd.src == SRC_CHAR) && char_blank;

    always_comb
    begin
        cur_byte  = SPACE_CHAR;
        cur_rs    = 1'b0;
        cur_lead  = '0;
        cur_after = WAIT_SHORT;
        unique case (cmd.src)
            SRC_INIT:
            begin
                cur_byte  = init_byte(cnt_reg[2:0]);
                cur_lead  = (cnt_reg == '0) ? POWER_UP_10US : 12'd0;
                cur_after = init_wait(cnt_reg[2:0]);
            end
            SRC_ADDR:
            begin
                cur_byte  = line_cmd(line_reg);
                cur_after = (line_reg == 2'd0) ? WAIT_LONG : WAIT_SHORT;
            end
            SRC_CHAR:
            begin
                cur_rs    = 1'b1;
                cur_byte  = (char_blank || !rd_valid_reg) ? SPACE_CHAR : rd_data_reg;
            end
            SRC_ERASE:
            begin
                cur_byte  = CMD_CLEAR;
                cur_after = WAIT_LONG;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_cell && pos_ok)
        begin
            mem[pos_addr] <= character;
        end
        if (cmd.fetch)
        begin
            rd_data_reg <= mem[cell_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            init_reg      <= 1'b0;
            blank_reg     <= 1'b0;
            cnt_reg       <= '0;
            cell_addr_reg <= '0;
            line_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_store)
            begin
                valid_reg <= '0;
            end
            else if (cmd.store_cell && pos_ok)
            begin
                valid_reg[pos_addr] <= 1'b1;
            end
            else if (blank_hit)
            begin
                valid_reg[cell_addr_reg] <= 1'b0;
            end

            if (cmd.set_init)
            begin
                init_reg <= 1'b1;
            end

            if (cmd.load_line)
            begin
                line_reg      <= line;
                cell_addr_reg <= CELL_W'(int'(line) * CHARS_PER_LINE);
                blank_reg     <= 1'b0;
            end
            else
            begin
                if (blank_hit)
                begin
                    blank_reg <= 1'b1;
                end
                if (cmd.cnt_inc)
                begin
                    cell_addr_reg <= cell_addr_reg + 1'b1;
                end
            end

            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (cmd.fetch)
            begin
                rd_valid_reg <= valid_reg[cell_addr_reg];
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rs_reg     <= cur_rs;
            nibble_reg <= cmd.low ? cur_byte[3:0] : cur_byte[7:4];
            lead_reg   <= cmd.low ? 12'd0 : cur_lead;
            after_reg  <= cmd.low ? cur_after : 9'd0;
            last_reg   <= cmd.last;
        end
    end

    assign status.out_free    = !out_valid_reg || !out_stall;
    assign status.initialized = init_reg;
    assign status.init_end    = (cnt_reg == CNT_W'(INIT_BYTES - 1));
    assign status.col_end     = (cnt_reg == CNT_W'(CHARS_PER_LINE - 1));
    assign status.line_ok     = (int'(line) < LINES);
    assign status.kind        = kind_t'(kind);

    assign out_valid       = out_valid_reg;
    assign reg_select      = rs_reg;
    assign nibble          = nibble_reg;
    assign lead_wait_10us  = lead_reg;
    assign wait_after_10us = after_reg;
    assign last            = last_reg;

endmodule

FILE: hdl/char_lcd_refresh_controller.sv
// Drives a character LCD on a 4-bit bus from a 4x20 text store. An init (when
// not yet initialized), erase or line refresh yields a burst of output beats,
// one per enable strobe (high nibble, then low nibble of each byte), with last
// set on the final beat. Storing a character gives no beat, nor does an init
// once initialized; init gives 16 beats and erase 2; a line refresh gives the
// address byte and then one byte per cell, each character preceded by a read
// of the single-port store. Output stalls hold the beats back. Input is taken
// only when the previous item's beats have all been handed to the output
// register. The store powers up as all spaces with no clearing pass.
module char_lcd_refresh_controller
    import lcdr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [6:0]  position,
    input  logic [7:0]  character,
    input  logic [1:0]  line,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        reg_select,
    output logic [3:0]  nibble,
    output logic [11:0] lead_wait_10us,
    output logic [8:0]  wait_after_10us,
    output logic        last
);

    lcdr_cmd_t    cmd;
    lcdr_status_t status;

    lcdr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    lcdr_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .kind            (kind),
        .position        (position),
        .character       (character),
        .line            (line),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .reg_select      (reg_select),
        .nibble          (nibble),
        .lead_wait_10us  (lead_wait_10us),
        .wait_after_10us (wait_after_10us),
        .last            (last)
    );

endmodule

FILE: tb/tb_char_lcd_refresh_controller.sv
`timescale 1ns / 1ps

module tb_char_lcd_refresh_controller
    import lcdr_pkg::*;
();

    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 100;
    localparam int RANDOM_ITEMS = 190;

    localparam logic [7:0] INIT_SEQ  [0:7] = '{8'h30, 8'h30, 8'h30, 8'h20,
                                               8'h08, 8'h0C, 8'h06, 8'h02};
    localparam logic [8:0] INIT_WAIT [0:7] = '{9'd500, 9'd20, 9'd20, 9'd5,
                                               9'd5, 9'd5, 9'd5, 9'd5};

    typedef struct {
        logic        rs;
        logic [3:0]  nib;
        logic [11:0] lead;
        logic [8:0]  after;
        logic        is_last;
    } strobe_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    kind_t       kind;
    logic [6:0]  position;
    logic [7:0]  character;
    logic [1:0]  line;
    logic        out_valid;
    logic        out_stall;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [11:0] lead_wait_10us;
    logic [8:0]  wait_after_10us;
    logic        last;

    // shadow of the display text and init flag
    logic [7:0]  shadow_text [CELLS];
    logic        shadow_init;
    strobe_t     strobe_q [$];

    int          mismatches  = 0;
    bit          tx_idle_on  = 1'b0;
    bit          rx_stall_on = 1'b0;
    bit          hold_req    = 1'b0;

    char_lcd_refresh_controller i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .position        (position),
        .character       (character),
        .line            (line),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .reg_select      (reg_select),
        .nibble          (nibble),
        .lead_wait_10us  (lead_wait_10us),
        .wait_after_10us (wait_after_10us),
        .last            (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [7:0] rand_char();
        if ($urandom_range(0, 9) == 0)
            return 8'h00;
        return 8'($urandom_range(1, 255));
    endfunction

    // one byte goes out as two beats, high nibble first
    function automatic void push_byte(logic rs, logic [7:0] b, logic [11:0] lead,
                                      logic [8:0] after, logic fin);
        strobe_t s;
        s.rs      = rs;
        s.nib     = b[7:4];
        s.lead    = lead;
        s.after   = '0;
        s.is_last = 1'b0;
        strobe_q.push_back(s);
        s.nib     = b[3:0];
        s.lead    = '0;
        s.after   = after;
        s.is_last = fin;
        strobe_q.push_back(s);
    endfunction

    function automatic void blank_text();
        int i;
        for (i = 0; i < CELLS; i++)
            shadow_text[i] = SPACE_CHAR;
    endfunction

    function automatic void predict_strobes(kind_t k, logic [6:0] p, logic [7:0] c,
                                            logic [1:0] ln);
        int         i;
        int         base;
        logic       blank;
        logic [7:0] addr;
        logic [8:0] wt;
        case (k)
            KIND_INIT:
            begin
                if (!shadow_init)
                begin
                    shadow_init = 1'b1;
                    blank_text();
                    for (i = 0; i < 8; i++)
                        push_byte(1'b0, INIT_SEQ[i], (i == 0) ? POWER_UP_10US : 12'd0,
                                  INIT_WAIT[i], i == 7);
                end
            end
            KIND_STORE:
            begin
                if (int'(p) < CELLS)
                    shadow_text[p] = c;
            end
            KIND_REFRESH:
            begin
                if (int'(ln) < LINES)
                begin
                    case (ln)
                        2'd0:    addr = 8'h02;
                        2'd1:    addr = 8'hC0;
                        2'd2:    addr = 8'h94;
                        default: addr = 8'hD4;
                    endcase
                    wt = (ln == 2'd0) ? WAIT_LONG : WAIT_SHORT;
                    push_byte(1'b0, addr, 12'd0, wt, 1'b0);
                    base  = int'(ln) * CHARS_PER_LINE;
                    blank = 1'b0;
                    // a zero ends the line: it and all later cells turn to spaces
                    for (i = 0; i < CHARS_PER_LINE; i++)
                    begin
                        if (shadow_text[base + i] == 8'h00)
                            blank = 1'b1;
                        if (blank)
                            shadow_text[base + i] = SPACE_CHAR;
                        push_byte(1'b1, shadow_text[base + i], 12'd0, WAIT_SHORT,
                                  i == CHARS_PER_LINE - 1);
                    end
                end
            end
            default:
            begin
                push_byte(1'b0, CMD_CLEAR, 12'd0, WAIT_LONG, 1'b1);
                blank_text();
            end
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic send_item(kind_t k, logic [6:0] p, logic [7:0] c, logic [1:0] ln);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind      <= k;
        position  <= p;
        character <= c;
        line      <= ln;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_strobes(k, p, c, ln);
        @(negedge clk);
    endtask

    task automatic store_char(int p, logic [7:0] c);
        send_item(KIND_STORE, 7'(p), c, 2'($urandom_range(0, 3)));
    endtask

    task automatic refresh_line(int ln);
        send_item(KIND_REFRESH, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                  2'(ln));
    endtask

    task automatic send_other(kind_t k);
        send_item(k, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                  2'($urandom_range(0, 3)));
    endtask

    task automatic drain_wait();
        in_valid <= 1'b0;
        wait (strobe_q.size() == 0);
        @(negedge clk);
    endtask

    task automatic test_before_init();
        store_char(5, 8'h41);
        refresh_line(0);
        send_other(KIND_ERASE);
    endtask

    task automatic test_init();
        send_other(KIND_INIT);
        send_other(KIND_INIT);
    endtask

    task automatic test_store_edges();
        store_char(0, 8'hFF);
        store_char(79, 8'h01);
        store_char(127, 8'h55);
        store_char(80, 8'hAA);
        store_char(19, 8'h80);
        store_char(40, 8'h00);
        store_char(64, 8'h7E);
        store_char(65, 8'h00);
        store_char(66, 8'h42);
    endtask

    task automatic test_refresh_lines();
        int ln;
        for (ln = 0; ln < LINES; ln++)
            refresh_line(ln);
        refresh_line(2);
    endtask

    task automatic test_erase();
        send_other(KIND_ERASE);
        refresh_line(3);
    endtask

    // receiver holds off while refreshes keep coming, so the block backs up
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
        store_char(21, 8'h5A);
        refresh_line(1);
        refresh_line(0);
        store_char(60, 8'hC3);
        refresh_line(3);
        send_other(KIND_ERASE);
        refresh_line(2);
        drain_wait();
    endtask

    task automatic test_random();
        int sent;
        int n;
        int ln;
        int r;
        int j;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                tx_idle_on  = $urandom_range(0, 3) != 0;
                rx_stall_on = $urandom_range(0, 3) != 0;
            end
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                // write a few cells of one line, then show it
                ln = $urandom_range(0, LINES - 1);
                n  = $urandom_range(1, 6);
                for (j = 0; j < n; j++)
                    store_char(ln * CHARS_PER_LINE + $urandom_range(0, CHARS_PER_LINE - 1),
                               rand_char());
                refresh_line(ln);
                sent += n + 1;
            end
            else
            begin
                if (r < 80)
                    refresh_line($urandom_range(0, 3));
                else if (r < 90)
                    store_char($urandom_range(0, 127), rand_char());
                else if (r < 97)
                    send_other(KIND_ERASE);
                else
                    send_other(KIND_INIT);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = KIND_INIT;
        position  = '0;
        character = '0;
        line      = '0;
        shadow_init = 1'b0;
        blank_text();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_before_init();
        test_init();
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
        test_store_edges();
        test_refresh_lines();
        test_erase();
        drain_wait();
        test_backpressure();
        test_random();

        in_valid <= 1'b0;
        wait (strobe_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (rx_stall_on && $urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_beats
        strobe_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (strobe_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: beat with none expected, expected nothing got rs %0d nib %h",
                         $time, reg_select, nibble);
            end
            else
            begin
                want = strobe_q.pop_front();
                check_field("reg_select", want.rs, reg_select);
                check_field("nibble", want.nib, nibble);
                check_field("lead_wait_10us", want.lead, lead_wait_10us);
                check_field("wait_after_10us", want.after, wait_after_10us);
                check_field("last", want.is_last, last);
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: no beat for %0d cycles, %0d beats outstanding",
                 $time, IDLE_LIMIT, strobe_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/lcdr_pkg.sv
hdl/lcdr_ctrl.sv
hdl/lcdr_dp.sv
hdl/char_lcd_refresh_controller.sv
tb/tb_char_lcd_refresh_controller.sv
